@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the Gaussian sample generator.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CGLS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CGLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cgls_pkg.sv @@
// Package of the Gaussian sample generator: register map, reset values,
// control struct and widths. No dependencies.
package cgls_pkg;

    localparam int FRACTION_BITS_DEF = 32;
    localparam int LCG_W             = 32;
    localparam int OUT_W             = 35;
    localparam int UNI24_W           = 24;
    localparam int DRAWS             = 6;
    localparam int DRAW_W            = 3;
    localparam int CFG_ADDR_W        = 5;
    localparam int CFG_DATA_W        = 32;
    localparam int REG_IDX_W         = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_COMBINED_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAIN_MUL      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAIN_INC      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEC_MUL       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SEC_INC       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAIN_SEED     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SEC_SEED      = 3'd6;

    localparam logic [LCG_W-1:0] RST_MAIN_MUL  = 32'd1664525;
    localparam logic [LCG_W-1:0] RST_MAIN_INC  = 32'd1013904223;
    localparam logic [LCG_W-1:0] RST_SEC_MUL   = 32'd69069;
    localparam logic [LCG_W-1:0] RST_SEC_INC   = 32'd3;
    localparam logic [LCG_W-1:0] RST_MAIN_SEED = 32'd0;
    localparam logic [LCG_W-1:0] RST_SEC_SEED  = 32'd1;

    typedef struct packed {
        logic             combined;
        logic [LCG_W-1:0] main_mul;
        logic [LCG_W-1:0] main_inc;
        logic [LCG_W-1:0] sec_mul;
        logic [LCG_W-1:0] sec_inc;
        logic [LCG_W-1:0] main_seed;
        logic [LCG_W-1:0] sec_seed;
    } t_cfg;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic load_seed;   // reload generators from the seed registers
        logic init_acc;    // start the sums of a new item
        logic step_main;   // shared unit steps the main generator
        logic step_sec;    // shared unit steps the second generator
        logic accumulate;  // fold the current uniform into the sums
        logic second_grp;  // current uniform belongs to the second group
        logic load_out;    // move the finished sums into the output register
    } t_ctrl;

endpackage

@@ hw/rtl/cgls_ifs.sv @@
// Valid/ready channel interfaces of the Gaussian sample generator.
// Depends on cgls_pkg for the payload widths.
interface cgls_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink   (input valid, input reseed, output ready);
endinterface

interface cgls_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [cgls_pkg::OUT_W-1:0]  real_part;
    logic signed [cgls_pkg::OUT_W-1:0]  imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

@@ hw/rtl/cgls_regs.sv @@
// APB-style configuration register file of the Gaussian sample generator.
// Depends on cgls_pkg.
module cgls_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cgls_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cgls_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cgls_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output cgls_pkg::t_cfg                    o_cfg
);

    cgls_pkg::t_cfg                   r_cfg;
    logic [cgls_pkg::REG_IDX_W-1:0]   w_idx;
    logic                             w_wr;

    assign w_idx  = paddr[cgls_pkg::CFG_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.combined  <= 1'b0;
            r_cfg.main_mul  <= cgls_pkg::RST_MAIN_MUL;
            r_cfg.main_inc  <= cgls_pkg::RST_MAIN_INC;
            r_cfg.sec_mul   <= cgls_pkg::RST_SEC_MUL;
            r_cfg.sec_inc   <= cgls_pkg::RST_SEC_INC;
            r_cfg.main_seed <= cgls_pkg::RST_MAIN_SEED;
            r_cfg.sec_seed  <= cgls_pkg::RST_SEC_SEED;
        end else if (w_wr) begin
            case (w_idx)
                cgls_pkg::REG_COMBINED_MODE: r_cfg.combined  <= pwdata[0];
                cgls_pkg::REG_MAIN_MUL:      r_cfg.main_mul  <= pwdata;
                cgls_pkg::REG_MAIN_INC:      r_cfg.main_inc  <= pwdata;
                cgls_pkg::REG_SEC_MUL:       r_cfg.sec_mul   <= pwdata;
                cgls_pkg::REG_SEC_INC:       r_cfg.sec_inc   <= pwdata;
                cgls_pkg::REG_MAIN_SEED:     r_cfg.main_seed <= pwdata;
                cgls_pkg::REG_SEC_SEED:      r_cfg.sec_seed  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cgls_pkg::REG_COMBINED_MODE: prdata = {31'd0, r_cfg.combined};
            cgls_pkg::REG_MAIN_MUL:      prdata = r_cfg.main_mul;
            cgls_pkg::REG_MAIN_INC:      prdata = r_cfg.main_inc;
            cgls_pkg::REG_SEC_MUL:       prdata = r_cfg.sec_mul;
            cgls_pkg::REG_SEC_INC:       prdata = r_cfg.sec_inc;
            cgls_pkg::REG_MAIN_SEED:     prdata = r_cfg.main_seed;
            cgls_pkg::REG_SEC_SEED:      prdata = r_cfg.sec_seed;
            default:                     prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/cgls_mac.sv @@
// Shared 32-bit multiply-add unit: y = a * b + c mod 2^32.
// Depends on cgls_pkg.
module cgls_mac (
    input  logic [cgls_pkg::LCG_W-1:0] i_a,
    input  logic [cgls_pkg::LCG_W-1:0] i_b,
    input  logic [cgls_pkg::LCG_W-1:0] i_c,
    output logic [cgls_pkg::LCG_W-1:0] o_y
);

    logic [2*cgls_pkg::LCG_W-1:0] w_prod;

    assign w_prod = i_a * i_b;
    assign o_y    = w_prod[cgls_pkg::LCG_W-1:0] + i_c;

endmodule

@@ hw/rtl/cgls_ctrl.sv @@
// Sequencer of the Gaussian sample generator: steps six draws through the
// shared multiply-add unit. Depends on cgls_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cgls_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_reseed,
    input  logic            i_combined,
    input  logic            i_out_busy,
    output logic            o_in_ready,
    output cgls_pkg::t_ctrl o_ctl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAIN = 3'd1;
    localparam logic [2:0] ST_SEC  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [cgls_pkg::DRAW_W-1:0] LAST_DRAW = cgls_pkg::DRAW_W'(cgls_pkg::DRAWS - 1);
    localparam logic [cgls_pkg::DRAW_W-1:0] GRP_SIZE  = cgls_pkg::DRAW_W'(cgls_pkg::DRAWS / 2);

    logic [2:0]                    r_state, n_state;
    logic [cgls_pkg::DRAW_W-1:0]   r_draw, n_draw;
    logic                          w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_draw  = r_draw;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_ctl.load_seed = i_reseed;
                    o_ctl.init_acc  = 1'b1;
                    n_draw          = '0;
                    n_state         = ST_MAIN;
                end
            end
            ST_MAIN: begin
                o_ctl.step_main = 1'b1;
                n_state         = i_combined ? ST_SEC : ST_ACC;
            end
            ST_SEC: begin
                o_ctl.step_sec = 1'b1;
                n_state        = ST_ACC;
            end
            ST_ACC: begin
                o_ctl.accumulate = 1'b1;
                o_ctl.second_grp = (r_draw >= GRP_SIZE);
                if (r_draw == LAST_DRAW) begin
                    n_state = ST_FIN;
                end else begin
                    n_draw  = r_draw + 1'b1;
                    n_state = ST_MAIN;
                end
            end
            ST_FIN: begin
                // hold the sums until the output register frees up
                if (!i_out_busy) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_draw  <= '0;
        end else begin
            r_state <= n_state;
            r_draw  <= n_draw;
        end
    end

    `CGLS_ASSERT(a_draw_range, i_clk, i_rst_n, r_draw <= LAST_DRAW, "draw count out of range")
    `CGLS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_rst_n && w_accept,
        r_state == ST_MAIN, "accepted item did not start a draw")
    `CGLS_ASSERT_NEXT(a_fin_release, i_clk, i_rst_n, r_state == ST_FIN && !i_out_busy,
        r_state == ST_IDLE, "finished item did not release the sequencer")

endmodule

@@ hw/rtl/cgls_datapath.sv @@
// Datapath of the Gaussian sample generator: generator state, shared
// multiply-add unit, running sums and output register.
// Depends on cgls_pkg, cgls_mac and assert_macros.svh.
`include "assert_macros.svh"
module cgls_datapath #(
    parameter int FRACTION_BITS = cgls_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cgls_pkg::t_cfg                    i_cfg,
    input  cgls_pkg::t_ctrl                   i_ctl,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_out_busy,
    output logic signed [cgls_pkg::OUT_W-1:0] o_real_part,
    output logic signed [cgls_pkg::OUT_W-1:0] o_imag_part
);

    localparam int SHR = cgls_pkg::LCG_W - FRACTION_BITS;
    localparam int SHL = FRACTION_BITS - cgls_pkg::UNI24_W;
    localparam logic [cgls_pkg::OUT_W-1:0] THREE = cgls_pkg::OUT_W'(3) << FRACTION_BITS;

    logic [cgls_pkg::LCG_W-1:0]    r_main, r_second, r_mark;
    logic [cgls_pkg::OUT_W-1:0]    r_re, r_im;
    logic [cgls_pkg::OUT_W-1:0]    r_out_re, r_out_im;
    logic                          r_out_valid;
    logic [cgls_pkg::LCG_W-1:0]    w_mac_a, w_mac_b, w_mac_c, w_mac_y;
    logic [cgls_pkg::LCG_W-1:0]    w_diff;
    logic [cgls_pkg::UNI24_W-1:0]  w_u24;
    logic [cgls_pkg::OUT_W-1:0]    w_uni;
    logic                          w_hit_mark;

    // one multiplier shared by both generators
    assign w_mac_a = i_ctl.step_sec ? i_cfg.sec_mul : i_cfg.main_mul;
    assign w_mac_b = i_ctl.step_sec ? r_second      : r_main;
    assign w_mac_c = i_ctl.step_sec ? i_cfg.sec_inc : i_cfg.main_inc;

    cgls_mac u_mac (
        .i_a (w_mac_a),
        .i_b (w_mac_b),
        .i_c (w_mac_c),
        .o_y (w_mac_y)
    );

    assign w_diff     = r_main - r_second;
    assign w_u24      = {w_diff[cgls_pkg::LCG_W-1:9], 1'b1};
    assign w_hit_mark = (r_second == r_mark);

    always_comb begin
        if (i_cfg.combined) begin
            w_uni = {{(cgls_pkg::OUT_W-cgls_pkg::UNI24_W){1'b0}}, w_u24} << SHL;
        end else begin
            w_uni = {{(cgls_pkg::OUT_W-cgls_pkg::LCG_W){1'b0}}, r_main} >> SHR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main   <= cgls_pkg::RST_MAIN_SEED;
            r_second <= cgls_pkg::RST_SEC_SEED;
            r_mark   <= cgls_pkg::RST_SEC_SEED;
        end else if (i_ctl.load_seed) begin
            r_main   <= i_cfg.main_seed;
            r_second <= i_cfg.sec_seed;
            r_mark   <= i_cfg.sec_seed;
        end else begin
            if (i_ctl.step_main) begin
                r_main <= w_mac_y;
            end
            if (i_ctl.step_sec) begin
                r_second <= w_mac_y;
            end
            // advance the second generator past its cycle mark
            if (i_ctl.accumulate && i_cfg.combined && w_hit_mark) begin
                r_second <= r_second + 1'b1;
                r_mark   <= r_mark + 1'b1;
            end
        end
    end

    // real sum counts down from three, imag adds the first group, subtracts the second
    always_ff @(posedge i_clk) begin
        if (i_ctl.init_acc) begin
            r_re <= THREE;
            r_im <= '0;
        end else if (i_ctl.accumulate) begin
            r_re <= r_re - w_uni;
            r_im <= i_ctl.second_grp ? (r_im - w_uni) : (r_im + w_uni);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_re <= r_re;
            r_out_im <= r_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_busy  = r_out_valid && !i_out_ready;
    assign o_real_part = r_out_re;
    assign o_imag_part = r_out_im;

    `CGLS_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, i_rst_n && i_ctl.load_out,
        r_out_valid, "output register loaded but not valid")
    `CGLS_ASSERT(a_no_overwrite, i_clk, i_rst_n, !(i_ctl.load_out && o_out_busy),
        "output register overwritten while item waits")

endmodule

@@ hw/rtl/complex_gaussian_lcg_sum_unit.sv @@
// Approximately Gaussian complex sample generator (sum of six uniforms).
// Channels: i_req (sink, valid/ready, field reseed) asks for one sample;
// o_rsp (source, valid/ready, real_part and imag_part, 35-bit signed with
// FRACTION_BITS fraction bits) returns it. The APB port (psel ... pready,
// byte address 4 * register index) sets mode, multipliers, increments and
// seeds; write it only while no item is in flight.
// Each item runs six draws through one shared 32x32 multiply-add unit; a draw
// steps through step and accumulate in simple mode, and through step main, step
// second and accumulate in combined mode. i_req is not ready while an item is in
// the sequencer and is ready again once its result is loaded into the output
// register. A new request is taken while the previous result still waits on
// o_rsp; a stalled receiver holds the sequencer, with the finished sums, in its
// finish state until the output register frees up. Reset clears the registers to
// their default values and loads the generators from the default seeds.
// Depends on cgls_pkg, cgls_ifs, cgls_regs, cgls_ctrl, cgls_datapath.
module complex_gaussian_lcg_sum_unit #(
    parameter int FRACTION_BITS = cgls_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cgls_req_if.sink                          i_req,
    cgls_rsp_if.source                        o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cgls_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cgls_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cgls_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    cgls_pkg::t_cfg  w_cfg;
    cgls_pkg::t_ctrl w_ctl;
    logic            w_in_ready;
    logic            w_out_busy;
    logic            w_out_valid;
    logic signed [cgls_pkg::OUT_W-1:0] w_real, w_imag;

    cgls_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cgls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_reseed   (i_req.reseed),
        .i_combined (w_cfg.combined),
        .i_out_busy (w_out_busy),
        .o_in_ready (w_in_ready),
        .o_ctl      (w_ctl)
    );

    cgls_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_ctl       (w_ctl),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (w_out_valid),
        .o_out_busy  (w_out_busy),
        .o_real_part (w_real),
        .o_imag_part (w_imag)
    );

    assign i_req.ready     = w_in_ready;
    assign o_rsp.valid     = w_out_valid;
    assign o_rsp.real_part = w_real;
    assign o_rsp.imag_part = w_imag;

endmodule

@@ bench/cgls_sample_checker.sv @@
// Scoreboard for the Gaussian sample generator: snoops the APB writes and the
// request channel, predicts each complex sample and checks the response channel.
// Depends on cgls_pkg and the channel interfaces in cgls_ifs.
`timescale 1ns / 1ps

module cgls_sample_checker #(
    parameter int FRAC_BITS = cgls_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cgls_req_if                             req_mon,
    cgls_rsp_if                             rsp_mon,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [cgls_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [cgls_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                              o_fail_count,
    output int                              o_outstanding,
    output int                              o_checked,
    output int                              o_mark_hits,
    output int                              o_combined_samples
);
    import cgls_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] real_part;
        logic [OUT_W-1:0] imag_part;
    } t_sample;

    t_cfg             cfg;
    logic [LCG_W-1:0] gen_main;
    logic [LCG_W-1:0] gen_sec;
    logic [LCG_W-1:0] sec_mark;
    t_sample          expected_samples[$];
    int               fail_count       = 0;
    int               checked          = 0;
    int               mark_hits        = 0;
    int               combined_samples = 0;

    // One uniform draw in [0,1) with FRAC_BITS fraction bits; advances the generators.
    function automatic logic [63:0] draw_uniform();
        logic [LCG_W-1:0] diff;
        gen_main = cfg.main_mul * gen_main + cfg.main_inc;
        if (!cfg.combined)
            return 64'(gen_main >> (LCG_W - FRAC_BITS));
        gen_sec = cfg.sec_mul * gen_sec + cfg.sec_inc;
        // difference uses the second generator before the cycle-mark bump
        diff = gen_main - gen_sec;
        if (gen_sec == sec_mark) begin
            gen_sec   = gen_sec + 1;
            sec_mark  = sec_mark + 1;
            mark_hits = mark_hits + 1;
        end
        diff = (diff >> 8) | 32'd1;
        return 64'(diff) << (FRAC_BITS - UNI24_W);
    endfunction

    function automatic t_sample gaussian_sample(logic reseed);
        logic [63:0] sum_a;
        logic [63:0] sum_b;
        t_sample     s;
        if (reseed) begin
            gen_main = cfg.main_seed;
            gen_sec  = cfg.sec_seed;
            sec_mark = cfg.sec_seed;
        end
        sum_a = '0;
        sum_b = '0;
        for (int k = 0; k < DRAWS; k++) begin
            if (k < DRAWS / 2)
                sum_a = sum_a + draw_uniform();
            else
                sum_b = sum_b + draw_uniform();
        end
        s.real_part = OUT_W'((64'd3 << FRAC_BITS) - sum_b - sum_a);
        s.imag_part = OUT_W'(sum_a - sum_b);
        return s;
    endfunction

    task automatic flag_mismatch(string field, logic [OUT_W-1:0] want_v,
                                 logic [OUT_W-1:0] got_v);
        fail_count = fail_count + 1;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        t_sample want;
        t_sample got;
        if (!i_rst_n) begin
            cfg = '{combined: 1'b0, main_mul: RST_MAIN_MUL, main_inc: RST_MAIN_INC,
                    sec_mul: RST_SEC_MUL, sec_inc: RST_SEC_INC,
                    main_seed: RST_MAIN_SEED, sec_seed: RST_SEC_SEED};
            gen_main = RST_MAIN_SEED;
            gen_sec  = RST_SEC_SEED;
            sec_mark = RST_SEC_SEED;
            expected_samples.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_ADDR_W-1:2])
                    REG_COMBINED_MODE: cfg.combined  = i_pwdata[0];
                    REG_MAIN_MUL:      cfg.main_mul  = i_pwdata;
                    REG_MAIN_INC:      cfg.main_inc  = i_pwdata;
                    REG_SEC_MUL:       cfg.sec_mul   = i_pwdata;
                    REG_SEC_INC:       cfg.sec_inc   = i_pwdata;
                    REG_MAIN_SEED:     cfg.main_seed = i_pwdata;
                    REG_SEC_SEED:      cfg.sec_seed  = i_pwdata;
                    default: ;
                endcase
            end
            if (req_mon.valid && req_mon.ready) begin
                if (cfg.combined)
                    combined_samples = combined_samples + 1;
                expected_samples.push_back(gaussian_sample(req_mon.reseed));
            end
            if (rsp_mon.valid && rsp_mon.ready) begin
                got = '{rsp_mon.real_part, rsp_mon.imag_part};
                if (expected_samples.size() == 0) begin
                    fail_count = fail_count + 1;
                    $display("%0t: unexpected item, expected none, got real %h imag %h",
                             $time, got.real_part, got.imag_part);
                end else begin
                    want = expected_samples.pop_front();
                    if (got.real_part !== want.real_part)
                        flag_mismatch("real_part", want.real_part, got.real_part);
                    if (got.imag_part !== want.imag_part)
                        flag_mismatch("imag_part", want.imag_part, got.imag_part);
                    checked = checked + 1;
                end
            end
        end
        // publish through nonblocking assignments so the stimulus side never races the update
        o_fail_count       <= fail_count;
        o_outstanding      <= expected_samples.size();
        o_checked          <= checked;
        o_mark_hits        <= mark_hits;
        o_combined_samples <= combined_samples;
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the Gaussian sample generator bench: clock, reset, APB programming,
// bursty requests and a stalling receiver; checking is done by cgls_sample_checker.
// Depends on cgls_pkg, cgls_ifs, the block's RTL and bench/cgls_sample_checker.sv.
`timescale 1ns / 1ps

module tb_top;
    import cgls_pkg::*;

    localparam int          RESET_CYCLES   = 7;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_ITEMS    = 117;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          IDLE_GAP       = 24;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int unsigned CYCLE_LIMIT    = 600000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  tx_valid  = 1'b0;
    logic                  tx_reseed = 1'b0;
    logic                  rx_ready  = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int          fail_count;
    int          outstanding;
    int          checked;
    int          mark_hits;
    int          combined_samples;
    int          items_sent     = 0;
    int          reseeds_sent   = 0;
    int          settings_used  = 1;
    int          hold_off_seq   = 0;
    int unsigned cycle_count    = 0;

    cgls_req_if req_if ();
    cgls_rsp_if rsp_if ();

    assign req_if.valid  = tx_valid;
    assign req_if.reseed = tx_reseed;
    assign rsp_if.ready  = rx_ready;

    always #1 i_clk = ~i_clk;

    complex_gaussian_lcg_sum_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cgls_sample_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .req_mon            (req_if),
        .rsp_mon            (rsp_if),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_pready           (pready),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .o_fail_count       (fail_count),
        .o_outstanding      (outstanding),
        .o_checked          (checked),
        .o_mark_hits        (mark_hits),
        .o_combined_samples (combined_samples)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d items outstanding",
                     cycle_count, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall pattern with a random run length; a bump of
    // hold_off_seq starts one long hold-off so the block backs up.
    int rx_mode     = 0;
    int rx_mode_left = 0;
    int hold_left   = 0;
    int hold_seen   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else if (hold_seen != hold_off_seq) begin
            hold_seen <= hold_off_seq;
            hold_left <= HOLD_CYCLES;
            rx_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(20, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       rx_ready <= 1'b1;
                1:       rx_ready <= 1'($urandom_range(0, 1));
                2:       rx_ready <= ($urandom_range(0, 7) != 0);
                default: rx_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Setup then access; the bus stays selected so writes chain, the caller releases it.
    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (outstanding != 0);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic program_all(logic [CFG_DATA_W-1:0] mode_word,
                               logic [LCG_W-1:0] main_mul, logic [LCG_W-1:0] main_inc,
                               logic [LCG_W-1:0] sec_mul, logic [LCG_W-1:0] sec_inc,
                               logic [LCG_W-1:0] main_seed, logic [LCG_W-1:0] sec_seed);
        wait_idle();
        apb_write(REG_COMBINED_MODE, mode_word);
        apb_write(REG_MAIN_MUL, main_mul);
        apb_write(REG_MAIN_INC, main_inc);
        apb_write(REG_SEC_MUL, sec_mul);
        apb_write(REG_SEC_INC, sec_inc);
        apb_write(REG_MAIN_SEED, main_seed);
        apb_write(REG_SEC_SEED, sec_seed);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // Hold valid until the item is taken; valid stays high for the caller.
    task automatic send_item(logic reseed);
        tx_valid  <= 1'b1;
        tx_reseed <= reseed;
        do @(posedge i_clk); while (!req_if.ready);
        items_sent++;
        if (reseed)
            reseeds_sent++;
    endtask

    task automatic send_directed(logic [7:0] reseeds, int count);
        for (int k = 0; k < count; k++)
            send_item(reseeds[k]);
        tx_valid <= 1'b0;
    endtask

    task automatic send_bursts(int count);
        int burst_left;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (n != 0 && $urandom_range(0, 3) != 0) begin
                    tx_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
            burst_left--;
            send_item($urandom_range(0, 9) == 0);
        end
        tx_valid <= 1'b0;
    endtask

    function automatic logic [LCG_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic             mode;
        logic [LCG_W-1:0] m_mul;
        logic [LCG_W-1:0] m_inc;
        logic [LCG_W-1:0] s_mul;
        logic [LCG_W-1:0] s_inc;
        logic [LCG_W-1:0] m_seed;
        logic [LCG_W-1:0] s_seed;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults, simple mode, with and without reseed
        send_directed(8'b0000_0010, 3);
        // combined mode, default generators
        program_all(32'd1, RST_MAIN_MUL, RST_MAIN_INC, RST_SEC_MUL, RST_SEC_INC,
                    RST_MAIN_SEED, RST_SEC_SEED);
        send_directed(8'b0000_0001, 3);
        // identical frozen generators: cycle mark on every draw, zero difference on the first draw, wrap
        program_all(32'd1, 32'd1, 32'd0, 32'd1, 32'd0, '1, '1);
        send_directed(8'b0000_0001, 2);
        // simple mode, all draws at the top of the range: most negative real part
        program_all(32'd0, 32'd0, '1, RST_SEC_MUL, RST_SEC_INC, '1, 32'd0);
        send_directed(8'b0000_0001, 2);
        // simple mode, all draws zero: real part exactly three
        program_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_directed(8'b0000_0001, 2);
        // combined mode, second generator lands on the mark once after reseed
        program_all(32'd1, 32'd0, 32'd0, 32'd0, 32'd5, 32'd0, 32'd5);
        send_directed(8'b0000_0001, 2);
        // all-ones coefficients in both generators
        program_all(32'd1, '1, '1, '1, '1, 32'd0, '1);
        send_directed(8'b0000_0001, 3);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode   = p[0];
            m_mul  = pick_word();
            m_inc  = pick_word();
            s_mul  = pick_word();
            s_inc  = pick_word();
            m_seed = pick_word();
            s_seed = pick_word();
            // steer the second generator onto its cycle mark
            if (mode && (p == 1 || $urandom_range(0, 2) == 0)) begin
                if ($urandom_range(0, 1) != 0) begin
                    s_mul = 32'd1;
                    s_inc = 32'd0;
                end else begin
                    s_mul = 32'd0;
                    s_inc = s_seed;
                end
            end
            program_all({31'($urandom), mode}, m_mul, m_inc, s_mul, s_inc, m_seed, s_seed);
            if (p == 0 || p == 5)
                hold_off_seq <= hold_off_seq + 1;
            send_bursts(PHASE_ITEMS);
        end

        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d samples (%0d sent, %0d with reseed) over %0d register settings;",
                 checked, items_sent, reseeds_sent, settings_used);
        $display("%0d samples in combined mode, %0d cycle-mark steps, 2 long receiver hold-offs.",
                 combined_samples, mark_hits);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
